FILE: hw/rtl/qps_pkg.sv
// Shared types and constants for the queue proportional sampler.
// Used by every module of the block except qps_ram; depends on nothing.
`timescale 1ns / 1ps

package qps_pkg;

   localparam int MODE_W   = 3;
   localparam int PORT_W   = 4;
   localparam int AMOUNT_W = 16;
   localparam int FRAC_W   = 20;
   localparam int VALUE_W  = 20;

   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PORT_W-1:0]   input_port;
      logic [PORT_W-1:0]   output_port;
      logic [AMOUNT_W-1:0] amount;
      logic [FRAC_W-1:0]   random_fraction;
   } req_type;

   typedef struct packed {
      logic [PORT_W-1:0]  chosen_port;
      logic [VALUE_W-1:0] value;
      logic               empty_res;
      logic               overflow;
   } rsp_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_LEAF  = 7'b0000100,
      ST_PATH  = 7'b0001000,
      ST_ROOT  = 7'b0010000,
      ST_WALK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

FILE: hw/rtl/queue_proportional_sampler.sv
// Queue proportional sampler: one sum tree per switch input kept in a RAM.
// Request channel (req_valid/req_stall/req_payload) carries a mode, the tree
// (input_port), the leaf (output_port), an amount and a 20-bit random fraction.
// Response channel (rsp_valid/rsp_stall/rsp_payload) returns one result per request.
// One request is processed at a time; req_stall is high while it is in flight.
// A request goes through these steps:
//   add, subtract, remove: leaf read, leaf write, then one path level per cycle
//   sample: root read and scaling multiply, then one tree level per cycle
//   read total: root read; out-of-range ports and undefined modes: straight to done.
// The pace is set by the single RAM read port and the one shared adder, which
// serve one tree level per cycle. The response sits in an output register, so a
// new request is taken while an earlier response waits; a further result waits
// internally until the receiver drops rsp_stall. After reset the block clears
// all INPUT_COUNT*2*LEAVES tree RAM entries (512 at default) one entry a cycle,
// holding req_stall high.
`timescale 1ns / 1ps

module queue_proportional_sampler #(
   parameter int INPUT_COUNT  = 16,
   parameter int OUTPUT_COUNT = 16,
   parameter int LEAVES       = 16,
   parameter int QUEUE_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qps_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qps_pkg::rsp_type  rsp_payload
);
   import qps_pkg::*;

   localparam int LOG_LEAVES = $clog2(LEAVES);
   localparam int NIDX_W     = LOG_LEAVES + 1;
   localparam int NODES      = 2 * LEAVES;
   localparam int NODE_W     = QUEUE_BITS + LOG_LEAVES;
   localparam int ALU_W      = ((NODE_W > AMOUNT_W) ? NODE_W : AMOUNT_W) + 1;
   localparam int TREE_W     = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int DEPTH      = INPUT_COUNT * NODES;
   localparam int RAM_AW     = $clog2(DEPTH);
   localparam int PROD_W     = FRAC_W + NODE_W;
   localparam int CMP_W      = 10;

   localparam logic [NODE_W-1:0] LEAF_MAX = NODE_W'({QUEUE_BITS{1'b1}});
   localparam logic [NIDX_W-1:0] ROOT     = NIDX_W'(1);
   localparam logic [NIDX_W-1:0] ROOT_L   = NIDX_W'(2);
   localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(DEPTH - 1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NIDX_W-1:0]  node_ff, node_in;
   logic [NODE_W-1:0]  sum_ff, sum_in;
   logic [NODE_W-1:0]  r_ff, r_in;
   logic [RAM_AW-1:0]  clr_ff, clr_in;

   logic               accept;
   logic               load_rsp;
   logic               in_ok, out_ok;
   logic               leaf_mode;
   logic [TREE_W-1:0]  tree_sel;
   logic [NIDX_W-1:0]  leaf_idx;
   logic [NIDX_W-1:0]  parent;
   logic [NIDX_W-1:0]  next_node;
   logic [NODE_W-1:0]  new_leaf;
   logic               sat;

   logic               wr_en;
   logic [RAM_AW-1:0]  wr_addr, rd_addr;
   logic [NODE_W-1:0]  wr_data, rd_data;

   logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
   alu_op_type         alu_op;
   logic               alu_neg;
   logic [PROD_W-1:0]  product;

   qps_ram #(
      .WIDTH (NODE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   qps_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .op     (alu_op),
      .result (alu_res),
      .neg    (alu_neg)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign in_ok  = CMP_W'(req_payload.input_port) < CMP_W'(INPUT_COUNT);
   assign out_ok = (CMP_W'(req_payload.output_port) < CMP_W'(OUTPUT_COUNT)) &&
                   (CMP_W'(req_payload.output_port) < CMP_W'(LEAVES));
   assign leaf_mode = (req_payload.mode == MODE_ADD) || (req_payload.mode == MODE_SUB) ||
                      (req_payload.mode == MODE_REMOVE);
   assign leaf_idx  = {1'b1, LOG_LEAVES'(req_payload.output_port)};

   assign tree_sel = (state_ff == ST_IDLE) ? TREE_W'(req_payload.input_port)
                                           : TREE_W'(req_ff.input_port);

   assign parent    = {1'b0, node_ff[NIDX_W-1:1]};
   assign next_node = {node_ff[NIDX_W-2:0], ~alu_neg};
   assign product   = PROD_W'(req_ff.random_fraction) * PROD_W'(rd_data);
   assign sat       = |alu_res[ALU_W-1:QUEUE_BITS];
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Operand selection for the shared adder.
   always_comb begin
      alu_a  = ALU_W'(rd_data);
      alu_b  = '0;
      alu_op = ALU_ADD;
      unique case (state_ff)
         ST_LEAF: begin
            alu_a  = ALU_W'(rd_data);
            alu_b  = ALU_W'(req_ff.amount);
            alu_op = (req_ff.mode == MODE_SUB) ? ALU_SUB : ALU_ADD;
         end
         ST_PATH: begin
            alu_a  = ALU_W'(sum_ff);
            alu_b  = ALU_W'(rd_data);
            alu_op = ALU_ADD;
         end
         ST_WALK: begin
            alu_a  = ALU_W'(r_ff);
            alu_b  = ALU_W'(rd_data);
            alu_op = ALU_SUB;
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      node_in  = node_ff;
      sum_in   = sum_ff;
      r_in     = r_ff;
      clr_in   = clr_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = RAM_AW'({tree_sel, node_ff});
      wr_data  = '0;
      rd_addr  = RAM_AW'({tree_sel, ROOT});
      new_leaf = rd_data;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + RAM_AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               res_in = '0;
               if (leaf_mode && in_ok && out_ok) begin
                  rd_addr  = RAM_AW'({tree_sel, leaf_idx});
                  node_in  = leaf_idx;
                  state_in = ST_LEAF;
               end else if ((req_payload.mode == MODE_SAMPLE ||
                             req_payload.mode == MODE_READ) && in_ok) begin
                  rd_addr  = RAM_AW'({tree_sel, ROOT});
                  state_in = ST_ROOT;
               end else begin
                  // Out-of-range ports or undefined mode: nothing to touch.
                  res_in.empty_res = (req_payload.mode == MODE_SAMPLE);
                  state_in         = ST_DONE;
               end
            end
         end
         ST_LEAF: begin
            unique case (req_ff.mode)
               MODE_ADD: begin
                  new_leaf        = sat ? LEAF_MAX : NODE_W'(alu_res);
                  res_in.overflow = sat;
               end
               MODE_SUB: begin
                  new_leaf        = alu_neg ? '0 : NODE_W'(alu_res);
                  res_in.overflow = alu_neg;
               end
               MODE_REMOVE: begin
                  new_leaf     = '0;
                  res_in.value = VALUE_W'(rd_data);
               end
               default: begin
                  new_leaf = rd_data;
               end
            endcase
            wr_en    = 1'b1;
            wr_addr  = RAM_AW'({tree_sel, node_ff});
            wr_data  = new_leaf;
            sum_in   = new_leaf;
            rd_addr  = RAM_AW'({tree_sel, node_ff ^ ROOT});
            state_in = ST_PATH;
         end
         ST_PATH: begin
            // Parent gets the fresh child sum plus the sibling just read.
            wr_en   = 1'b1;
            wr_addr = RAM_AW'({tree_sel, parent});
            wr_data = NODE_W'(alu_res);
            sum_in  = NODE_W'(alu_res);
            node_in = parent;
            rd_addr = RAM_AW'({tree_sel, parent ^ ROOT});
            if (parent == ROOT) begin
               state_in = ST_DONE;
            end
         end
         ST_ROOT: begin
            if (req_ff.mode == MODE_READ) begin
               res_in.value = VALUE_W'(rd_data);
               state_in     = ST_DONE;
            end else if (rd_data == '0) begin
               res_in.empty_res = 1'b1;
               state_in         = ST_DONE;
            end else begin
               r_in     = product[PROD_W-1:FRAC_W];
               node_in  = ROOT;
               rd_addr  = RAM_AW'({tree_sel, ROOT_L});
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // Go left while r is below the left sum, else subtract and go right.
            if (!alu_neg) begin
               r_in = NODE_W'(alu_res);
            end
            node_in = next_node;
            rd_addr = RAM_AW'({tree_sel, next_node[NIDX_W-2:0], 1'b0});
            if (next_node[NIDX_W-1]) begin
               res_in.chosen_port = PORT_W'(next_node[LOG_LEAVES-1:0]);
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      node_ff <= node_in;
      sum_ff  <= sum_in;
      r_ff    <= r_in;
   end

endmodule

FILE: hw/rtl/qps_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// Standalone; no package dependency.
`timescale 1ns / 1ps

module qps_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/qps_alu.sv
// Shared add/subtract unit used for leaf updates, path sums and the sample walk.
// Depends on qps_pkg for the operation type.
`timescale 1ns / 1ps

module qps_alu #(
   parameter int WIDTH = 21
) (
   input  logic [WIDTH-1:0]   a,
   input  logic [WIDTH-1:0]   b,
   input  qps_pkg::alu_op_type op,
   output logic [WIDTH-1:0]   result,
   output logic               neg
);
   import qps_pkg::*;

   logic [WIDTH-1:0] b_eff;

   assign b_eff  = (op == ALU_SUB) ? ~b : b;
   assign result = a + b_eff + WIDTH'(op == ALU_SUB);
   // Operands stay below the top bit, so a set top bit means a < b.
   assign neg    = result[WIDTH-1];

endmodule

FILE: hw/rtl/qps_checker.sv
// Port-level checks for the queue proportional sampler, bound to the top level.
// Depends on qps_pkg for the payload types.
`timescale 1ns / 1ps

module qps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qps_pkg::rsp_type rsp_payload
);
   import qps_pkg::*;

   // Reset starts the clearing sweep: no request taken, no response shown.
   assert property (@(posedge clock) reset |=> (req_stall && !rsp_valid))
      else $error("request taken or response shown right after reset");

   // One request at a time: the cycle after an accept is always stalled.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted back to back");

   // An empty sample reports nothing else.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.empty_res) |->
      (rsp_payload.chosen_port == '0 && rsp_payload.value == '0 &&
       !rsp_payload.overflow))
      else $error("empty response carries other fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind queue_proportional_sampler qps_checker u_qps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: tb/testbench.sv
// Self-checking testbench for queue_proportional_sampler: directed and random
// requests checked against an in-bench model of the sum trees.
// Depends on qps_pkg for the request and response types and mode codes.
`timescale 1ns / 1ps

module testbench;
   import qps_pkg::*;

   localparam int TREES     = 16;
   localparam int LEAF_BASE = 16;
   localparam int TREE_NODES = 2 * LEAF_BASE;
   localparam logic [31:0] LEAF_MAX = 32'h0000_FFFF;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int MAX_REPORTS = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   queue_proportional_sampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // model state: node 1 is the root, leaf of output d at LEAF_BASE + d
   logic [31:0] tree_sum [TREES][TREE_NODES];

   req_type queued_requests [$];
   rsp_type awaited_results [$];
   logic    req_fire = 1'b0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      mismatch_count = 0;
   int      result_count = 0;
   int      mode_count [8];
   int      saturation_count = 0;
   int      empty_count = 0;

   function automatic void refresh_sums(int tree, int node);
      int parent;
      parent = node >> 1;
      while (parent >= 1) begin
         tree_sum[tree][parent] = tree_sum[tree][2*parent] + tree_sum[tree][2*parent+1];
         parent = parent >> 1;
      end
   endfunction

   // update the trees for one request and return the response it must produce
   function automatic rsp_type apply_request(req_type r);
      rsp_type     res;
      int          tree;
      int          leaf;
      int          node;
      logic [31:0] level;
      logic [39:0] frac_wide;
      logic [39:0] scaled;
      logic [31:0] remaining;
      res = '0;
      tree = r.input_port;
      leaf = LEAF_BASE + r.output_port;
      case (r.mode)
         MODE_ADD: begin
            level = tree_sum[tree][leaf] + r.amount;
            if (level > LEAF_MAX) begin
               level = LEAF_MAX;
               res.overflow = 1'b1;
            end
            tree_sum[tree][leaf] = level;
            refresh_sums(tree, leaf);
         end
         MODE_SUB: begin
            if (r.amount > tree_sum[tree][leaf]) begin
               tree_sum[tree][leaf] = '0;
               res.overflow = 1'b1;
            end else begin
               tree_sum[tree][leaf] = tree_sum[tree][leaf] - r.amount;
            end
            refresh_sums(tree, leaf);
         end
         MODE_SAMPLE: begin
            if (tree_sum[tree][1] == 0) begin
               res.empty_res = 1'b1;
            end else begin
               frac_wide = r.random_fraction;
               scaled = frac_wide * tree_sum[tree][1];
               remaining = scaled[39:20];
               node = 1;
               // go left while below the left sum, else skip past it
               while (node < LEAF_BASE) begin
                  if (remaining < tree_sum[tree][2*node]) begin
                     node = 2 * node;
                  end else begin
                     remaining = remaining - tree_sum[tree][2*node];
                     node = 2 * node + 1;
                  end
               end
               res.chosen_port = PORT_W'(node - LEAF_BASE);
            end
         end
         MODE_REMOVE: begin
            res.value = VALUE_W'(tree_sum[tree][leaf]);
            tree_sum[tree][leaf] = '0;
            refresh_sums(tree, leaf);
         end
         MODE_READ: begin
            res.value = VALUE_W'(tree_sum[tree][1]);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void queue_request(logic [2:0] mode, int tree, int port,
                                         int amount, int fraction);
      req_type r;
      r.mode = mode;
      r.input_port = PORT_W'(tree);
      r.output_port = PORT_W'(port);
      r.amount = AMOUNT_W'(amount);
      r.random_fraction = FRAC_W'(fraction);
      queued_requests.insert(queued_requests.size(), r);
   endfunction

   // mostly updates and samples on a few busy trees, with noise everywhere
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 35) r.mode = MODE_ADD;
      else if (pick < 50) r.mode = MODE_SUB;
      else if (pick < 75) r.mode = MODE_SAMPLE;
      else if (pick < 83) r.mode = MODE_REMOVE;
      else if (pick < 93) r.mode = MODE_READ;
      else r.mode = MODE_W'($urandom_range(7, 5));
      r.input_port = PORT_W'(($urandom_range(99) < 60) ? $urandom_range(3)
                                                       : $urandom_range(15));
      r.output_port = PORT_W'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 60) r.amount = AMOUNT_W'($urandom_range(255));
      else if (pick < 85) r.amount = AMOUNT_W'($urandom_range(16'hFFFF));
      else r.amount = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      pick = $urandom_range(99);
      if (pick < 90) r.random_fraction = FRAC_W'($urandom_range(20'hFFFFF));
      else r.random_fraction = $urandom_range(1) ? 20'hFFFFF : 20'h00000;
      return r;
   endfunction

   // driver: present the next request, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
      end else if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_payload <= queued_requests.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      req_fire = req_valid && !req_stall && !reset;
      if (req_fire) begin
         predicted = apply_request(req_payload);
         mode_count[req_payload.mode] = mode_count[req_payload.mode] + 1;
         if (predicted.overflow) saturation_count = saturation_count + 1;
         if (predicted.empty_res) empty_count = empty_count + 1;
         awaited_results.insert(awaited_results.size(), predicted);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count = result_count + 1;
         if (awaited_results.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected response %h", $realtime, rsp_payload);
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_payload.chosen_port !== oldest.chosen_port ||
                rsp_payload.value !== oldest.value ||
                rsp_payload.empty_res !== oldest.empty_res ||
                rsp_payload.overflow !== oldest.overflow) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: response %0d expected port %0d value %h empty %b ovf %b,",
                            " got port %0d value %h empty %b ovf %b"},
                           $realtime, result_count, oldest.chosen_port, oldest.value,
                           oldest.empty_res, oldest.overflow, rsp_payload.chosen_port,
                           rsp_payload.value, rsp_payload.empty_res, rsp_payload.overflow);
            end
         end
      end
   end

   task automatic drain();
      while (queued_requests.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase(int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RANDOM_PER_PHASE) queued_requests.insert(queued_requests.size(), random_request());
      drain();
   endtask

   initial begin
      foreach (tree_sum[t, n]) tree_sum[t][n] = '0;
      foreach (mode_count[m]) mode_count[m] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tree, saturation both ways, sample extremes, remove, bad modes
      queue_request(MODE_READ,   0,  0, 0,       0);
      queue_request(MODE_SAMPLE, 0,  0, 0,       20'hFFFFF);
      queue_request(MODE_ADD,    0,  0, 16'hFFFF, 0);
      queue_request(MODE_ADD,    0,  0, 1,       0);
      queue_request(MODE_ADD,    0, 15, 100,     0);
      queue_request(MODE_SUB,    0, 15, 200,     0);
      queue_request(MODE_ADD,    0,  5, 300,     0);
      queue_request(MODE_ADD,    0, 15, 0,       0);
      queue_request(MODE_ADD,    0, 10, 1,       0);
      queue_request(MODE_SAMPLE, 0,  0, 0,       0);
      queue_request(MODE_SAMPLE, 0,  0, 0,       20'hFFFFF);
      queue_request(MODE_SAMPLE, 0,  7, 16'hFFFF, 20'h80000);
      queue_request(MODE_READ,   0,  0, 0,       0);
      queue_request(MODE_REMOVE, 0,  0, 0,       0);
      queue_request(MODE_REMOVE, 0,  0, 0,       0);
      queue_request(MODE_SUB,    0,  5, 0,       0);
      queue_request(MODE_SUB,    0,  5, 300,     0);
      queue_request(MODE_ADD,   15, 15, 16'hFFFF, 0);
      queue_request(MODE_SAMPLE,15,  3, 0,       20'hFFFFF);
      queue_request(MODE_READ,  15,  0, 0,       0);
      queue_request(3'd5,       15, 15, 16'hFFFF, 20'hFFFFF);
      queue_request(3'd6,        9,  9, 16'h5555, 20'hAAAAA);
      queue_request(3'd7,       15, 15, 16'hFFFF, 20'hFFFFF);
      queue_request(MODE_READ,  15,  0, 0,       0);
      drain();

      run_random_phase(0, 0);
      run_random_phase(76, 0);
      run_random_phase(0, 76);
      run_random_phase(15, 15);

      repeat (20) @(posedge clock);
      $display("Covered %0d add, %0d sub, %0d sample, %0d remove, %0d read, %0d undefined",
               mode_count[MODE_ADD], mode_count[MODE_SUB], mode_count[MODE_SAMPLE],
               mode_count[MODE_REMOVE], mode_count[MODE_READ],
               mode_count[5] + mode_count[6] + mode_count[7]);
      $display("%0d responses checked, %0d saturations, %0d empty samples",
               result_count, saturation_count, empty_count);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  awaited_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d requests queued and %0d responses awaited",
               queued_requests.size(), awaited_results.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/qps_pkg.sv
hw/rtl/qps_ram.sv
hw/rtl/qps_alu.sv
hw/rtl/queue_proportional_sampler.sv
hw/rtl/qps_checker.sv
tb/testbench.sv
